>>> hw/rtl/arpm_pkg.sv
// Package for the audio RMS and peak meter: widths, codes, job and queue types.
// Used by every module of the meter; depends on nothing else.
`default_nettype none

package arpm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAG_BITS    = SAMPLE_BITS + 1;
   localparam int SQUARE_BITS = 2 * SAMPLE_BITS;
   localparam int SUM_BITS    = 64;
   localparam int COUNT_BITS  = 32;
   localparam int ROOT_BITS   = SUM_BITS / 2;
   localparam int LEVEL_BITS  = 16;
   localparam int LIMIT_BITS  = 8;
   localparam int THRESH_BITS = 16;

   localparam int RSP_DATA_BITS = 72;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_STEPS     = SUM_BITS;
   localparam int SQRT_STEPS    = ROOT_BITS;
   localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [LIMIT_BITS-1:0]  CHUNK_LIMIT_RESET = 8'd20;
   localparam logic [THRESH_BITS-1:0] SILENCE_RESET     = 16'd20;

   // Request kinds carried on tuser.
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHUNK_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SILENCE     = 1'd1;

   typedef struct packed {
      logic [SUM_BITS-1:0]   sum;
      logic [COUNT_BITS-1:0] count;
      logic [MAG_BITS-1:0]   peak;
   } arpm_job_type;

   // A job together with its valid bit, used for queue write and queue head.
   typedef struct packed {
      logic         valid;
      arpm_job_type job;
   } arpm_slot_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SQRT = 4'b0100,
      ST_DONE = 4'b1000
   } arpm_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/arpm_front.sv
// Front end of the meter: takes requests, squares and accumulates samples,
// and hands a finished measurement to the job queue. Uses arpm_pkg.
`default_nettype none

module arpm_front
   import arpm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [SAMPLE_BITS-1:0]    req_tdata,
   input  wire logic                      req_tuser,
   input  wire logic                      req_tlast,
   input  wire logic [LIMIT_BITS-1:0]     chunk_limit,
   input  wire logic [QUEUE_CNT_BITS-1:0] queue_used,
   output arpm_slot_type                  push
);

   logic                    accept;
   logic                    measuring;
   logic [LIMIT_BITS-1:0]   chunks_next;
   logic signed [MAG_BITS-1:0] sample_ext;

   logic                    stg_valid_ff, stg_valid_in;
   logic                    stg_restart_ff, stg_restart_in;
   logic                    stg_report_ff, stg_report_in;
   logic [SQUARE_BITS-1:0]  stg_square_ff, stg_square_in;
   logic [MAG_BITS-1:0]     stg_mag_ff, stg_mag_in;
   logic [LIMIT_BITS-1:0]   chunks_done_ff, chunks_done_in;

   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [MAG_BITS-1:0]     peak_ff, peak_in;

   logic [SUM_BITS-1:0]     sum_new;
   logic [COUNT_BITS-1:0]   count_new;
   logic [MAG_BITS-1:0]     peak_new;
   logic [QUEUE_CNT_BITS:0] credit_used;

   // A report still in the stage register has a queue slot reserved.
   assign credit_used = {1'b0, queue_used} + {{QUEUE_CNT_BITS{1'b0}},
                                              (stg_valid_ff & stg_report_ff)};
   assign req_tready  = credit_used < (QUEUE_CNT_BITS + 1)'(QUEUE_DEPTH);
   assign accept      = req_tvalid & req_tready;
   assign measuring   = chunks_done_ff < chunk_limit;
   assign chunks_next = chunks_done_ff + LIMIT_BITS'(1);
   assign sample_ext  = {req_tdata[SAMPLE_BITS-1], req_tdata};

   always_comb begin
      stg_valid_in   = 1'b0;
      stg_restart_in = 1'b0;
      stg_report_in  = 1'b0;
      stg_square_in  = SQUARE_BITS'(sample_ext) * SQUARE_BITS'(sample_ext);
      stg_mag_in     = sample_ext[MAG_BITS-1] ? (~sample_ext + MAG_BITS'(1)) : sample_ext;
      chunks_done_in = chunks_done_ff;
      if (accept) begin
         if (req_tuser == KIND_RESTART) begin
            stg_valid_in   = 1'b1;
            stg_restart_in = 1'b1;
            chunks_done_in = '0;
         end else if (measuring) begin
            stg_valid_in = 1'b1;
            if (req_tlast) begin
               chunks_done_in = chunks_next;
               stg_report_in  = chunks_next == chunk_limit;
            end
         end
      end
   end

   assign sum_new   = sum_ff + {{(SUM_BITS-SQUARE_BITS){1'b0}}, stg_square_ff};
   assign count_new = count_ff + COUNT_BITS'(1);
   assign peak_new  = (stg_mag_ff > peak_ff) ? stg_mag_ff : peak_ff;

   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      peak_in    = peak_ff;
      push.valid = 1'b0;
      push.job   = '{sum: sum_new, count: count_new, peak: peak_new};
      if (stg_valid_ff) begin
         if (stg_restart_ff) begin
            sum_in   = '0;
            count_in = '0;
            peak_in  = '0;
         end else begin
            sum_in     = sum_new;
            count_in   = count_new;
            peak_in    = peak_new;
            // A sample count that wrapped to zero ends the measurement silently.
            push.valid = stg_report_ff & (count_new != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff   <= 1'b0;
         chunks_done_ff <= '0;
         sum_ff         <= '0;
         count_ff       <= '0;
         peak_ff        <= '0;
      end else begin
         stg_valid_ff   <= stg_valid_in;
         chunks_done_ff <= chunks_done_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         peak_ff        <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_restart_ff <= stg_restart_in;
      stg_report_ff  <= stg_report_in;
      stg_square_ff  <= stg_square_in;
      stg_mag_ff     <= stg_mag_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == KIND_RESTART |=> chunks_done_ff == '0)
      else $error("chunk counter not cleared by a restart request");

endmodule

`default_nettype wire

>>> hw/rtl/arpm_queue.sv
// Short job queue between the accumulating front end and the arithmetic back end.
// Holds finished measurements in registers. Uses arpm_pkg.
`default_nettype none

module arpm_queue
   import arpm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire arpm_slot_type             push,
   input  wire logic                      pop,
   output arpm_slot_type                  head,
   output logic [QUEUE_CNT_BITS-1:0]      used
);

   arpm_job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   used_ff, used_in;
   logic                        do_pop;

   assign do_pop     = pop & (used_ff != '0);
   assign head.valid = used_ff != '0;
   assign head.job   = entry_ff[rd_ptr_ff];
   assign used       = used_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.valid);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(do_pop);
      used_in   = used_ff + QUEUE_CNT_BITS'(push.valid) - QUEUE_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> used_ff < QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("job pushed into a full queue");

endmodule

`default_nettype wire

>>> hw/rtl/arpm_back.sv
// Back end of the meter: restoring divide of the sum by the count, bit-serial
// square root, and the result register. Uses arpm_pkg.
`default_nettype none

module arpm_back
   import arpm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire arpm_slot_type             head,
   output logic                           pop,
   input  wire logic [THRESH_BITS-1:0]    silence_threshold,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata
);

   arpm_state_type             state_ff, state_in;
   logic [STEP_CNT_BITS-1:0]   step_ff, step_in;
   logic [SUM_BITS-1:0]        work_ff, work_in;     // dividend/quotient, then radicand
   logic [COUNT_BITS-1:0]      div_d_ff, div_d_in;
   logic [COUNT_BITS-1:0]      rem_ff, rem_in;
   logic [ROOT_BITS+1:0]       sq_rem_ff, sq_rem_in;
   logic [ROOT_BITS-1:0]       root_ff, root_in;
   logic [MAG_BITS-1:0]        peak_ff, peak_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS:0]        div_trial;
   logic                       div_ge;
   logic [ROOT_BITS+3:0]       sq_trial_rem;
   logic [ROOT_BITS+3:0]       sq_trial;
   logic                       sq_ge;
   logic                       out_free;
   logic [LEVEL_BITS-1:0]      rms_sat;
   logic [LEVEL_BITS-1:0]      peak_sat;
   logic                       silent;

   assign div_trial    = {rem_ff, work_ff[SUM_BITS-1]};
   assign div_ge       = div_trial >= {1'b0, div_d_ff};
   assign sq_trial_rem = {sq_rem_ff, work_ff[SUM_BITS-1 -: 2]};
   assign sq_trial     = {2'b00, root_ff, 2'b01};
   assign sq_ge        = sq_trial_rem >= sq_trial;
   assign out_free     = ~rsp_valid_ff | rsp_tready;

   assign rms_sat  = (root_ff > ROOT_BITS'({LEVEL_BITS{1'b1}})) ?
                     {LEVEL_BITS{1'b1}} : root_ff[LEVEL_BITS-1:0];
   assign peak_sat = (peak_ff > MAG_BITS'({LEVEL_BITS{1'b1}})) ?
                     {LEVEL_BITS{1'b1}} : peak_ff[LEVEL_BITS-1:0];
   // The silence decision uses the root before saturation.
   assign silent   = root_ff < ROOT_BITS'(silence_threshold);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      work_in      = work_ff;
      div_d_in     = div_d_ff;
      rem_in       = rem_ff;
      sq_rem_in    = sq_rem_ff;
      root_in      = root_ff;
      peak_in      = peak_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               work_in  = head.job.sum;
               div_d_in = head.job.count;
               peak_in  = head.job.peak;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? COUNT_BITS'(div_trial - {1'b0, div_d_ff})
                             : div_trial[COUNT_BITS-1:0];
            work_in = {work_ff[SUM_BITS-2:0], div_ge};
            step_in = step_ff + STEP_CNT_BITS'(1);
            if (step_ff == STEP_CNT_BITS'(DIV_STEPS - 1)) begin
               // The quotient now sits in the work register as the radicand.
               step_in   = '0;
               sq_rem_in = '0;
               root_in   = '0;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_rem_in = sq_ge ? (ROOT_BITS + 2)'(sq_trial_rem - sq_trial)
                              : sq_trial_rem[ROOT_BITS+1:0];
            root_in   = {root_ff[ROOT_BITS-2:0], sq_ge};
            work_in   = {work_ff[SUM_BITS-3:0], 2'b00};
            step_in   = step_ff + STEP_CNT_BITS'(1);
            if (step_ff == STEP_CNT_BITS'(SQRT_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, silent, div_d_ff, peak_sat, rms_sat};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      work_ff     <= work_in;
      div_d_ff    <= div_d_in;
      rem_ff      <= rem_in;
      sq_rem_ff   <= sq_rem_in;
      root_ff     <= root_in;
      peak_ff     <= peak_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < div_d_ff)
      else $error("division remainder not below the divisor");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT |-> sq_rem_ff <= {1'b0, root_ff, 1'b0})
      else $error("square root remainder above twice the partial root");

endmodule

`default_nettype wire

>>> hw/rtl/audio_rms_peak_meter.sv
// A request that completes a measurement goes through the front-end stage register,
// the job queue, 64 divide steps, 32 root steps and the output register.
// Throughput: one request per cycle while the queue has room; the back end takes one
// measurement at a time, bit-serially; a two-entry job queue decouples the sides.
// Reset (synchronous, active high) clears accumulators, queue and output valid, and
// sets chunk_limit and silence_threshold to 20.
`default_nettype none

module audio_rms_peak_meter
   import arpm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [SAMPLE_BITS-1:0]    req_tdata,   // sample
   input  wire logic                      req_tuser,   // kind
   input  wire logic                      req_tlast,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,   // rms_level, peak_level,
                                                        // sample_total, near_silent
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [THRESH_BITS-1:0]    csr_wdata
);

   logic [LIMIT_BITS-1:0]     chunk_limit_ff, chunk_limit_in;
   logic [THRESH_BITS-1:0]    silence_ff, silence_in;
   arpm_slot_type             push;
   arpm_slot_type             head;
   logic                      pop;
   logic [QUEUE_CNT_BITS-1:0] queue_used;

   always_comb begin
      chunk_limit_in = chunk_limit_ff;
      silence_in     = silence_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHUNK_LIMIT: chunk_limit_in = csr_wdata[LIMIT_BITS-1:0];
            CSR_SILENCE:     silence_in     = csr_wdata;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_limit_ff <= CHUNK_LIMIT_RESET;
         silence_ff     <= SILENCE_RESET;
      end else begin
         chunk_limit_ff <= chunk_limit_in;
         silence_ff     <= silence_in;
      end
   end

   arpm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .chunk_limit (chunk_limit_ff),
      .queue_used  (queue_used),
      .push        (push)
   );

   arpm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .used  (queue_used)
   );

   arpm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .silence_threshold (silence_ff),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> verif/tb_audio_rms_peak_meter.sv
// Self-checking testbench for audio_rms_peak_meter: drives sample and restart requests,
// predicts each level report in a small scoreboard and compares every report field by field.
// Depends on arpm_pkg and the audio_rms_peak_meter RTL only.
`default_nettype none

module tb_audio_rms_peak_meter
   import arpm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] rms;
      logic [LEVEL_BITS-1:0] peak;
      logic [COUNT_BITS-1:0] total;
      logic                  quiet;
   } level_report_type;

   // Tracks the meter's accumulators and holds the level reports still to arrive.
   class level_board;
      logic [LIMIT_BITS-1:0]  chunk_limit;
      logic [THRESH_BITS-1:0] threshold;
      logic [SUM_BITS-1:0]    square_sum;
      logic [MAG_BITS-1:0]    peak_abs;
      logic [COUNT_BITS-1:0]  sample_count;
      logic [LIMIT_BITS-1:0]  chunks_done;
      level_report_type       reports[$];
      int                     faults;

      function new();
         chunk_limit  = CHUNK_LIMIT_RESET;
         threshold    = SILENCE_RESET;
         faults       = 0;
         clear();
      endfunction

      function void clear();
         square_sum   = '0;
         peak_abs     = '0;
         sample_count = '0;
         chunks_done  = '0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index, logic [THRESH_BITS-1:0] value);
         if (index == CSR_CHUNK_LIMIT) begin
            chunk_limit = value[LIMIT_BITS-1:0];
         end else begin
            threshold = value;
         end
      endfunction

      function logic [31:0] floor_sqrt(logic [63:0] x);
         logic [31:0] root;
         logic [63:0] trial;
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = {32'd0, root | (32'd1 << b)};
            if (trial * trial <= x) begin
               root = trial[31:0];
            end
         end
         return root;
      endfunction

      // Returns 1 when the request changed the state, 0 when the meter ignores it.
      function bit note_request(logic kind, logic [SAMPLE_BITS-1:0] sample, logic last);
         longint           value;
         logic [63:0]      mean;
         logic [31:0]      root;
         level_report_type report;
         if (kind == KIND_RESTART) begin
            clear();
            return 1;
         end
         if (chunks_done >= chunk_limit) begin
            return 0;
         end
         value = longint'($signed(sample));
         square_sum += 64'(value * value);
         if (value < 0) begin
            value = -value;
         end
         if (value > longint'(peak_abs)) begin
            peak_abs = MAG_BITS'(value);
         end
         sample_count += 1;
         if (!last) begin
            return 1;
         end
         chunks_done += 1;
         if (chunks_done == chunk_limit && sample_count != 0) begin
            mean         = square_sum / 64'(sample_count);
            root         = floor_sqrt(mean);
            report.rms   = (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
            report.peak  = (peak_abs > 17'hFFFF) ? 16'hFFFF : peak_abs[15:0];
            report.total = sample_count;
            report.quiet = (root < 32'(threshold));
            reports.push_back(report);
         end
         return 1;
      endfunction

      function void check_report(logic [RSP_DATA_BITS-1:0] data);
         level_report_type want;
         level_report_type got;
         got.rms   = data[15:0];
         got.peak  = data[31:16];
         got.total = data[63:32];
         got.quiet = data[64];
         if (reports.size() == 0) begin
            faults++;
            if (faults <= 10) begin
               $display("unexpected level report: rms %0d peak %0d total %0d quiet %0b",
                        got.rms, got.peak, got.total, got.quiet);
            end
            return;
         end
         want = reports.pop_front();
         if (got.rms != want.rms || got.peak != want.peak || got.total != want.total ||
             got.quiet != want.quiet) begin
            faults++;
            if (faults <= 10) begin
               $display("level report mismatch (expected/actual): rms %0d/%0d peak %0d/%0d",
                        want.rms, got.rms, want.peak, got.peak);
               $display("   total %0d/%0d quiet %0b/%0b",
                        want.total, got.total, want.quiet, got.quiet);
            end
         end
      endfunction
   endclass

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [SAMPLE_BITS-1:0]      req_tdata  = '0;   // sample
   logic                        req_tuser  = 1'b0; // kind
   logic                        req_tlast  = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]    rsp_tdata;         // rms_level, peak_level,
                                                   // sample_total, near_silent
   logic                        csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index  = '0;
   logic [THRESH_BITS-1:0]      csr_wdata  = '0;

   level_board board = new();
   bit         calm     = 1'b0;
   bit         hold_req = 1'b0;
   int         taken    = 0;

   audio_rms_peak_meter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         1: return 16'(int'($urandom_range(0, 40)) - 20);
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [THRESH_BITS-1:0] pick_threshold();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'hFFFF;
         3: return 16'($urandom_range(1, 64));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_item(logic kind, logic [SAMPLE_BITS-1:0] sample, logic last);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= sample;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (board.note_request(kind, sample, last)) begin
         taken++;
      end
      @(negedge clock);
   endtask

   task automatic set_levels(logic [LIMIT_BITS-1:0] limit, logic [THRESH_BITS-1:0] thresh);
      csr_we    <= 1'b1;
      csr_index <= CSR_CHUNK_LIMIT;
      csr_wdata <= 16'(limit);
      board.set_register(CSR_CHUNK_LIMIT, 16'(limit));
      @(negedge clock);
      csr_index <= CSR_SILENCE;
      csr_wdata <= thresh;
      board.set_register(CSR_SILENCE, thresh);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Lets every pending report drain, then covers the back end's latency.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.reports.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // Restart, then the configured number of chunks; a few runs are cut short or
   // followed by samples that arrive after the measurement is complete.
   task automatic run_measurements(int count, int max_len);
      int chunks;
      int len;
      repeat (count) begin
         send_item(KIND_RESTART, pick_sample(), 1'($urandom_range(0, 1)));
         chunks = board.chunk_limit;
         if ($urandom_range(0, 14) == 0) begin
            chunks = $urandom_range(0, chunks - 1);
         end
         repeat (chunks) begin
            len = $urandom_range(1, max_len);
            for (int i = 0; i < len; i++) begin
               send_item(KIND_SAMPLE, pick_sample(), i == len - 1);
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               send_item(KIND_SAMPLE, pick_sample(), 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_report(rsp_tdata);
      end
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Full-scale and silent measurements, most of a single sample; a sample after the
      // report is ignored until the restart.
      set_levels(8'd1, 16'd32768);
      send_item(KIND_SAMPLE, 16'h0001, 1'b0);
      send_item(KIND_SAMPLE, 16'h8000, 1'b1);
      send_item(KIND_SAMPLE, 16'h7FFF, 1'b1);
      send_item(KIND_RESTART, 16'hFFFF, 1'b1);
      send_item(KIND_SAMPLE, 16'h7FFF, 1'b1);
      send_item(KIND_RESTART, 16'h0000, 1'b0);
      send_item(KIND_SAMPLE, 16'h8000, 1'b1);
      send_item(KIND_RESTART, 16'h5A5A, 1'b1);
      send_item(KIND_SAMPLE, 16'h0000, 1'b1);
      wait_idle();

      // With a chunk limit of zero every sample is dropped.
      set_levels(8'd0, 16'd0);
      send_item(KIND_RESTART, 16'hA5A5, 1'b0);
      send_item(KIND_SAMPLE, 16'h1234, 1'b1);
      send_item(KIND_SAMPLE, 16'hFFFF, 1'b0);
      wait_idle();

      // Limit moved under a measurement: lowered to the chunks done, then raised.
      set_levels(8'd3, 16'hFFFF);
      send_item(KIND_SAMPLE, 16'hFFFF, 1'b1);
      send_item(KIND_SAMPLE, 16'h0010, 1'b1);
      wait_idle();
      set_levels(8'd2, 16'hFFFF);
      send_item(KIND_SAMPLE, 16'h0100, 1'b1);
      wait_idle();
      set_levels(8'd4, 16'd20);
      send_item(KIND_SAMPLE, 16'hFFF0, 1'b1);
      send_item(KIND_SAMPLE, 16'h0003, 1'b1);
      wait_idle();

      // The receiver stalls while every other request completes a measurement.
      set_levels(8'd1, 16'd100);
      hold_req = 1'b1;
      repeat (12) begin
         send_item(KIND_RESTART, pick_sample(), 1'b0);
         send_item(KIND_SAMPLE, pick_sample(), 1'b1);
      end
      wait_idle();

      set_levels(8'd255, 16'hFFFF);
      run_measurements(1, 1);
      wait_idle();
      set_levels(8'd1, 16'd0);
      run_measurements(10, 4);

      while (taken < 650) begin
         wait_idle();
         if (taken >= 560) begin
            calm = 1'b1;
         end
         set_levels(8'($urandom_range(1, 6)), pick_threshold());
         run_measurements(6, 6);
      end

      // The closing stretch runs without idle cycles on either side.
      calm = 1'b1;
      wait_idle();
      set_levels(8'd3, pick_threshold());
      run_measurements(6, 4);
      wait_idle();

      if (board.faults == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
